// File: sv/pnm_pkg.sv
// Shared types for the PNM header parser.
`default_nettype none
package pnm_pkg;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_DIGITS  = 2'd1,
      STATUS_RANGE      = 2'd2,
      STATUS_INCOMPLETE = 2'd3
   } status_type;

   // Which header content line comes next.
   typedef enum logic [1:0] {
      LINE_MAGIC = 2'd0,
      LINE_SIZE  = 2'd1,
      LINE_MAX   = 2'd2,
      LINE_DONE  = 2'd3
   } line_type;

   // Progress through one decimal number.
   typedef enum logic [1:0] {
      NUM_LEAD   = 2'd0,
      NUM_SIGN   = 2'd1,
      NUM_DIGITS = 2'd2,
      NUM_STOP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         magic_digit;
      logic signed [31:0] column_count;
      logic signed [31:0] row_total;
      logic signed [31:0] max_sample;
   } rsp_type;

endpackage
`default_nettype wire

// File: sv/pnm_req_if.sv
// Byte channel into the parser.
`default_nettype none
interface pnm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface
`default_nettype wire

// File: sv/pnm_rsp_if.sv
// Result channel out of the parser.
`default_nettype none
interface pnm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [3:0]         magic_digit;
   logic signed [31:0] column_count;
   logic signed [31:0] row_total;
   logic signed [31:0] max_sample;

   modport source (output valid, output status, output magic_digit, output column_count,
                   output row_total, output max_sample, input ready);
   modport sink   (input valid, input status, input magic_digit, input column_count,
                   input row_total, input max_sample, output ready);
endinterface
`default_nettype wire

// File: sv/pnm_header_parser.sv
// PNM header parser top level: input register, parse step and result queue.
//
//   channel | dir | beat                              | accepted when
//   req_bus | in  | data_byte, end_of_file            | valid && ready
//   rsp_bus | out | status, magic_digit, column_count, | valid && ready
//           |     | row_total, max_sample             |
//
// One byte per cycle sustained while the result queue has room; a result passes
// through the input register, then the parse step, into the queue before it leaves.
// The parse step updates all line and number state together.
// Reset is synchronous and restarts the parser as at the start of a file.
// A two-entry result queue absorbs stalls on rsp_bus; req_bus.ready drops only
// while the queue is full and the input register holds a byte.
`default_nettype none
module pnm_header_parser (
   input  wire logic clock,
   input  wire logic reset,
   pnm_req_if.sink   req_bus,
   pnm_rsp_if.source rsp_bus
);
   import pnm_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff;
   logic     fifo_full;
   logic     advance;
   logic     step_valid;
   rsp_type  step_result;
   rsp_type  out_data;

   assign advance       = in_valid_ff && !fifo_full;
   assign req_bus.ready = !in_valid_ff || !fifo_full;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff.data_byte   <= req_bus.data_byte;
         in_item_ff.end_of_file <= req_bus.end_of_file;
      end
   end

   pnm_step u_step (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (advance),
      .item         (in_item_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   pnm_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (step_valid),
      .push_data  (step_result),
      .full       (fifo_full),
      .pop_valid  (rsp_bus.valid),
      .pop_data   (out_data),
      .pop_ready  (rsp_bus.ready)
   );

   assign rsp_bus.status       = out_data.status;
   assign rsp_bus.magic_digit  = out_data.magic_digit;
   assign rsp_bus.column_count = out_data.column_count;
   assign rsp_bus.row_total    = out_data.row_total;
   assign rsp_bus.max_sample   = out_data.max_sample;

endmodule
`default_nettype wire

// File: sv/pnm_step.sv
// Per-byte header parse: line tracking, number reading and result decision.
`default_nettype none
module pnm_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire pnm_pkg::req_type  item,
   output logic                   result_valid,
   output pnm_pkg::rsp_type       result
);
   import pnm_pkg::*;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_HASH  = 8'd35;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [35:0] NEG_LIMIT = 36'h0_8000_0000;
   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

   line_type    line_ff, line_in;
   logic [1:0]  pos_ff, pos_in;
   logic        comment_ff, comment_in;
   logic        blank_ff, blank_in;
   phase_type   phase_ff, phase_in;
   logic        rowpart_ff, rowpart_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        digits_ff, digits_in;
   logic        ovf_ff, ovf_in;
   status_type  lerr_ff, lerr_in;
   logic [31:0] pend_ff, pend_in;
   logic [3:0]  magic_ff, magic_in;
   logic [31:0] cols_ff, cols_in;
   logic [31:0] rows_ff, rows_in;
   logic        reported_ff, reported_in;

   // number close-out
   status_type  fin_status;
   logic [31:0] fin_value;

   // end-of-line decision on the held state
   logic        el_emit;
   status_type  el_status;
   logic [31:0] el_max;
   line_type    el_line;
   logic [31:0] el_cols;
   logic [31:0] el_rows;

   // number reader fed with the current byte
   phase_type   fd_phase;
   logic        fd_neg;
   logic        fd_digits;
   logic        fd_ovf;
   logic [31:0] fd_acc;
   logic [35:0] acc_wide;
   logic [35:0] acc_next;

   logic [7:0]  b;
   logic        b_digit;
   logic        b_space;
   logic        b_blank;
   logic        line_clear;
   logic        full_reset;

   assign b       = item.data_byte;
   assign b_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign b_space = ((b >= CHAR_TAB) && (b <= CHAR_CR)) || (b == CHAR_SPACE);
   assign b_blank = (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_NUL);

   always_comb begin
      fin_value = 32'd0;
      if (!digits_ff) begin
         fin_status = STATUS_NO_DIGITS;
      end else if (ovf_ff) begin
         fin_status = STATUS_RANGE;
      end else if (neg_ff) begin
         fin_status = STATUS_OK;
         fin_value  = 32'd0 - acc_ff;
      end else if (acc_ff > POS_LIMIT) begin
         fin_status = STATUS_RANGE;
      end else begin
         fin_status = STATUS_OK;
         fin_value  = acc_ff;
      end
   end

   always_comb begin
      el_emit   = 1'b0;
      el_status = STATUS_OK;
      el_max    = 32'd0;
      el_line   = line_ff;
      el_cols   = cols_ff;
      el_rows   = rows_ff;
      if (!(comment_ff || blank_ff)) begin
         unique case (line_ff)
            LINE_MAGIC: begin
               if (lerr_ff != STATUS_OK || pos_ff < 2'd2) begin
                  el_emit   = 1'b1;
                  el_status = STATUS_NO_DIGITS;
               end else begin
                  el_line = LINE_SIZE;
               end
            end
            LINE_SIZE: begin
               if (!rowpart_ff) begin
                  el_emit   = 1'b1;
                  el_status = STATUS_NO_DIGITS;
               end else if (lerr_ff != STATUS_OK) begin
                  el_emit   = 1'b1;
                  el_status = lerr_ff;
               end else if (fin_status != STATUS_OK) begin
                  el_emit   = 1'b1;
                  el_status = fin_status;
               end else begin
                  el_cols = pend_ff;
                  el_rows = fin_value;
                  el_line = LINE_MAX;
               end
            end
            LINE_MAX, LINE_DONE: begin
               el_emit   = 1'b1;
               el_status = fin_status;
               el_max    = (fin_status == STATUS_OK) ? fin_value : 32'd0;
               el_line   = LINE_DONE;
            end
            default: el_line = line_ff;
         endcase
      end
   end

   assign acc_wide = {4'd0, acc_ff};
   assign acc_next = (acc_wide << 3) + (acc_wide << 1) + {32'd0, b[3:0]};

   always_comb begin
      fd_phase  = phase_ff;
      fd_neg    = neg_ff;
      fd_digits = digits_ff;
      fd_ovf    = ovf_ff;
      fd_acc    = acc_ff;
      priority if (phase_ff == NUM_STOP) begin
         fd_phase = NUM_STOP;
      end else if (phase_ff == NUM_LEAD && b_space) begin
         fd_phase = NUM_LEAD;
      end else if (phase_ff == NUM_LEAD && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
         fd_neg   = (b == CHAR_MINUS);
         fd_phase = NUM_SIGN;
      end else if (!b_digit) begin
         fd_phase = NUM_STOP;
      end else begin
         fd_digits = 1'b1;
         fd_phase  = NUM_DIGITS;
         if (!ovf_ff) begin
            if (acc_next > NEG_LIMIT) begin
               fd_ovf = 1'b1;
            end else begin
               fd_acc = acc_next[31:0];
            end
         end
      end
   end

   always_comb begin
      line_in     = line_ff;
      pos_in      = pos_ff;
      comment_in  = comment_ff;
      blank_in    = blank_ff;
      phase_in    = phase_ff;
      rowpart_in  = rowpart_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      digits_in   = digits_ff;
      ovf_in      = ovf_ff;
      lerr_in     = lerr_ff;
      pend_in     = pend_ff;
      magic_in    = magic_ff;
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      reported_in = reported_ff;
      line_clear  = 1'b0;
      full_reset  = 1'b0;

      result_valid        = 1'b0;
      result.status       = el_status;
      result.magic_digit  = magic_ff;
      result.column_count = el_cols;
      result.row_total    = el_rows;
      result.max_sample   = el_max;

      if (item_valid) begin
         if (item.end_of_file) begin
            // flush the partial line, report once, then start over
            if (!reported_ff) begin
               result_valid = 1'b1;
               if (!(pos_ff != 2'd0 && el_emit)) begin
                  result.status     = STATUS_INCOMPLETE;
                  result.max_sample = 32'd0;
               end
            end
            full_reset = 1'b1;
            line_clear = 1'b1;
         end else if (!reported_ff) begin
            if (b == CHAR_LF) begin
               line_in    = el_line;
               cols_in    = el_cols;
               rows_in    = el_rows;
               line_clear = 1'b1;
               if (el_emit) begin
                  result_valid = 1'b1;
                  reported_in  = 1'b1;
               end
            end else begin
               comment_in = comment_ff || (pos_ff == 2'd0 && b == CHAR_HASH);
               blank_in   = blank_ff && b_blank;
               if (!comment_in) begin
                  unique case (line_ff)
                     LINE_MAGIC: begin
                        if (pos_ff == 2'd1) begin
                           if (b_digit) begin
                              magic_in = b[3:0];
                           end else begin
                              lerr_in = STATUS_NO_DIGITS;
                           end
                        end
                     end
                     LINE_SIZE: begin
                        if (!rowpart_ff && (b == CHAR_SPACE || b == CHAR_TAB)) begin
                           // close the column number, restart for rows
                           if (fin_status != STATUS_OK) begin
                              lerr_in = fin_status;
                           end else begin
                              pend_in = fin_value;
                           end
                           rowpart_in = 1'b1;
                           phase_in   = NUM_LEAD;
                           acc_in     = 32'd0;
                           neg_in     = 1'b0;
                           digits_in  = 1'b0;
                           ovf_in     = 1'b0;
                        end else begin
                           phase_in  = fd_phase;
                           acc_in    = fd_acc;
                           neg_in    = fd_neg;
                           digits_in = fd_digits;
                           ovf_in    = fd_ovf;
                        end
                     end
                     LINE_MAX, LINE_DONE: begin
                        phase_in  = fd_phase;
                        acc_in    = fd_acc;
                        neg_in    = fd_neg;
                        digits_in = fd_digits;
                        ovf_in    = fd_ovf;
                     end
                     default: phase_in = phase_ff;
                  endcase
               end
               if (pos_ff != 2'd3) begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
      end

      if (line_clear) begin
         pos_in     = 2'd0;
         comment_in = 1'b0;
         blank_in   = 1'b1;
         phase_in   = NUM_LEAD;
         rowpart_in = 1'b0;
         acc_in     = 32'd0;
         neg_in     = 1'b0;
         digits_in  = 1'b0;
         ovf_in     = 1'b0;
         lerr_in    = STATUS_OK;
      end
      if (full_reset) begin
         line_in     = LINE_MAGIC;
         pend_in     = 32'd0;
         magic_in    = 4'd0;
         cols_in     = 32'd0;
         rows_in     = 32'd0;
         reported_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= LINE_MAGIC;
         pos_ff      <= 2'd0;
         comment_ff  <= 1'b0;
         blank_ff    <= 1'b1;
         phase_ff    <= NUM_LEAD;
         rowpart_ff  <= 1'b0;
         acc_ff      <= 32'd0;
         neg_ff      <= 1'b0;
         digits_ff   <= 1'b0;
         ovf_ff      <= 1'b0;
         lerr_ff     <= STATUS_OK;
         pend_ff     <= 32'd0;
         magic_ff    <= 4'd0;
         cols_ff     <= 32'd0;
         rows_ff     <= 32'd0;
         reported_ff <= 1'b0;
      end else begin
         line_ff     <= line_in;
         pos_ff      <= pos_in;
         comment_ff  <= comment_in;
         blank_ff    <= blank_in;
         phase_ff    <= phase_in;
         rowpart_ff  <= rowpart_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         digits_ff   <= digits_in;
         ovf_ff      <= ovf_in;
         lerr_ff     <= lerr_in;
         pend_ff     <= pend_in;
         magic_ff    <= magic_in;
         cols_ff     <= cols_in;
         rows_ff     <= rows_in;
         reported_ff <= reported_in;
      end
   end

   a_silent_after_report: assert property (@(posedge clock) disable iff (reset)
      item_valid && reported_ff && !item.end_of_file |-> !result_valid)
      else $error("result raised after the header was already reported");

   a_report_latches: assert property (@(posedge clock) disable iff (reset)
      result_valid && !item.end_of_file |=> reported_ff)
      else $error("report not recorded");

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.end_of_file |=> line_ff == LINE_MAGIC && !reported_ff && blank_ff)
      else $error("end of file did not restart the parser");

endmodule
`default_nettype wire

// File: sv/pnm_rsp_fifo.sv
// Two-entry result queue between the parse step and the result channel.
`default_nettype none
module pnm_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire pnm_pkg::rsp_type  push_data,
   output logic                   full,
   output logic                   pop_valid,
   output pnm_pkg::rsp_type       pop_data,
   input  wire logic              pop_ready
);
   import pnm_pkg::*;

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   rsp_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 pop;

   assign full      = (count_ff == FULL_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("result pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count out of range");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking bench for the PNM header parser: directed and random PNM files, bursty sender, stalling sink.
`default_nettype none
module testbench;
   import pnm_pkg::*;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam int         RANDOM_BYTES = 1250;
   localparam int         HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pnm_req_if req_bus ();
   pnm_rsp_if rsp_bus ();

   pnm_header_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_type    file_bytes[$];
   logic [7:0] file_buf[$];
   rsp_type    expected_headers[$];
   int         fail_count = 0;

   // Parser state as predicted
   line_type    hdr_line;
   logic [1:0]  line_pos;
   logic        in_comment;
   logic        all_blank;
   logic        row_part;
   phase_type   num_phase;
   logic [31:0] accum;
   logic        negative;
   logic        have_digits;
   logic        too_big;
   status_type  line_fault;
   logic [31:0] pending_cols;
   logic [3:0]  kept_magic;
   logic [31:0] kept_cols;
   logic [31:0] kept_rows;
   logic        done;

   function automatic bit is_numeral(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic void number_clear();
      num_phase   = NUM_LEAD;
      accum       = '0;
      negative    = 1'b0;
      have_digits = 1'b0;
      too_big     = 1'b0;
   endfunction

   function automatic void line_clear();
      line_pos   = '0;
      in_comment = 1'b0;
      all_blank  = 1'b1;
      row_part   = 1'b0;
      line_fault = STATUS_OK;
      number_clear();
   endfunction

   function automatic void parser_restart();
      hdr_line     = LINE_MAGIC;
      pending_cols = '0;
      kept_magic   = '0;
      kept_cols    = '0;
      kept_rows    = '0;
      done         = 1'b0;
      line_clear();
   endfunction

   // stoi-style digit accumulation; the magnitude freezes once out of range
   function automatic void number_take(logic [7:0] b);
      logic [63:0] grown;
      if (num_phase == NUM_STOP)
         return;
      if (num_phase == NUM_LEAD && ((b >= CH_TAB && b <= CH_CR) || b == CH_SPACE))
         return;
      if (num_phase == NUM_LEAD && (b == CH_PLUS || b == CH_MINUS)) begin
         negative  = (b == CH_MINUS);
         num_phase = NUM_SIGN;
         return;
      end
      if (!is_numeral(b)) begin
         num_phase = NUM_STOP;
         return;
      end
      have_digits = 1'b1;
      if (!too_big) begin
         grown = {32'd0, accum} * 64'd10 + {56'd0, b - CH_ZERO};
         if (grown > 64'd2147483648)
            too_big = 1'b1;
         else
            accum = grown[31:0];
      end
      num_phase = NUM_DIGITS;
   endfunction

   function automatic status_type number_settle(output logic [31:0] value);
      value = '0;
      if (!have_digits)
         return STATUS_NO_DIGITS;
      if (too_big)
         return STATUS_RANGE;
      if (negative) begin
         value = -accum;
         return STATUS_OK;
      end
      if (accum > 32'h7FFF_FFFF)
         return STATUS_RANGE;
      value = accum;
      return STATUS_OK;
   endfunction

   function automatic bit report(status_type st, logic [31:0] top, output rsp_type r);
      r.status       = st;
      r.magic_digit  = kept_magic;
      r.column_count = kept_cols;
      r.row_total    = kept_rows;
      r.max_sample   = top;
      done           = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit line_close(output rsp_type r);
      logic [31:0] value;
      status_type  st;
      bit          got;
      got = 1'b0;
      r   = '0;
      if (in_comment || all_blank) begin
         line_clear();
         return 1'b0;
      end
      case (hdr_line)
         LINE_MAGIC: begin
            if (line_fault != STATUS_OK || line_pos < 2'd2)
               got = report(STATUS_NO_DIGITS, '0, r);
            else
               hdr_line = LINE_SIZE;
         end
         LINE_SIZE: begin
            if (!row_part)
               got = report(STATUS_NO_DIGITS, '0, r);
            else if (line_fault != STATUS_OK)
               got = report(line_fault, '0, r);
            else begin
               st = number_settle(value);
               if (st != STATUS_OK)
                  got = report(st, '0, r);
               else begin
                  kept_cols = pending_cols;
                  kept_rows = value;
                  hdr_line  = LINE_MAX;
               end
            end
         end
         default: begin
            st       = number_settle(value);
            hdr_line = LINE_DONE;
            got      = report(st, (st == STATUS_OK) ? value : 32'd0, r);
         end
      endcase
      line_clear();
      return got;
   endfunction

   // Advance the predicted parser by one beat; returns 1 when a header result is due
   function automatic bit header_step(logic [7:0] b, logic eof, output rsp_type r);
      logic [1:0]  pos;
      logic [31:0] value;
      status_type  st;
      bit          got;
      got = 1'b0;
      r   = '0;
      if (eof) begin
         if (!done && line_pos != 2'd0)
            got = line_close(r);
         if (!done)
            got = report(STATUS_INCOMPLETE, '0, r);
         parser_restart();
         return got;
      end
      if (done)
         return 1'b0;
      if (b == CH_NL)
         return line_close(r);
      pos = line_pos;
      if (pos == 2'd0 && b == CH_HASH)
         in_comment = 1'b1;
      if (!(b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NUL))
         all_blank = 1'b0;
      if (!in_comment) begin
         case (hdr_line)
            LINE_MAGIC: begin
               if (pos == 2'd1) begin
                  if (is_numeral(b))
                     kept_magic = 4'(b - CH_ZERO);
                  else
                     line_fault = STATUS_NO_DIGITS;
               end
            end
            LINE_SIZE: begin
               // first space or tab closes the column count
               if (!row_part && (b == CH_SPACE || b == CH_TAB)) begin
                  st = number_settle(value);
                  if (st != STATUS_OK)
                     line_fault = st;
                  else
                     pending_cols = value;
                  row_part = 1'b1;
                  number_clear();
               end
               number_take(b);
            end
            default: number_take(b);
         endcase
      end
      if (pos < 2'd3)
         line_pos = pos + 2'd1;
      return 1'b0;
   endfunction

   function automatic void field_check(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Stimulus construction
   function automatic logic [7:0] any_but_newline();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CH_NL)
         b = CH_SPACE;
      return b;
   endfunction

   task automatic put(logic [7:0] b);
      file_buf.push_back(b);
   endtask

   task automatic put_eof();
      req_type item;
      foreach (file_buf[i]) begin
         item.data_byte   = file_buf[i];
         item.end_of_file = 1'b0;
         file_bytes.push_back(item);
      end
      file_buf.delete();
      item.data_byte   = 8'($urandom_range(0, 255));
      item.end_of_file = 1'b1;
      file_bytes.push_back(item);
   endtask

   task automatic put_number(bit spaces_ok);
      longint unsigned v;
      string           text;
      int              n;
      int              kind;
      logic [7:0]      lead[5];
      lead = '{CH_VT, 8'h0C, CH_CR, CH_SPACE, CH_TAB};
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n)
         put(lead[$urandom_range(0, spaces_ok ? 4 : 2)]);
      case ($urandom_range(0, 7))
         0: put(CH_PLUS);
         1, 2: put(CH_MINUS);
         3: if ($urandom_range(0, 3) == 0) begin
               put(CH_MINUS);
               put(CH_PLUS);
            end
         default: ;
      endcase
      kind = $urandom_range(0, 11);
      case (kind)
         0: v = 0;
         1: v = 64'd2147483647;
         2: v = 64'd2147483648;
         3: v = 64'd2147483649;
         4: v = $urandom();
         6: v = $urandom_range(0, 9);
         default: v = $urandom_range(0, 65535);
      endcase
      if (kind == 0) begin
         // no digits at all
      end else if (kind == 5) begin
         repeat ($urandom_range(11, 14))
            put(8'(CH_ZERO + $urandom_range(0, 9)));
      end else begin
         if (kind == 6)
            repeat ($urandom_range(1, 12))
               put(CH_ZERO);
         text = $sformatf("%0d", v);
         for (int i = 0; i < text.len(); i++)
            put(text[i]);
      end
      if ($urandom_range(0, 3) == 0)
         put(any_but_newline());
   endtask

   task automatic put_filler();
      int lines;
      logic [7:0] blanks[4];
      blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_NUL};
      lines = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (lines) begin
         if ($urandom_range(0, 1) == 0) begin
            put(CH_HASH);
            repeat ($urandom_range(0, 6))
               put(any_but_newline());
         end else begin
            repeat ($urandom_range(0, 3))
               put(blanks[$urandom_range(0, 3)]);
         end
         put(CH_NL);
      end
   endtask

   task automatic make_file();
      int         r;
      int         cut;
      logic [7:0] sep;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 30))
            put(($urandom_range(0, 4) == 0) ? CH_NL : 8'($urandom_range(0, 255)));
         put_eof();
         return;
      end
      put_filler();
      r = $urandom_range(0, 19);
      put((r == 0) ? any_but_newline() : CH_P);
      if (r != 1) begin
         put((r == 2) ? any_but_newline() : 8'(CH_ZERO + $urandom_range(0, 9)));
         repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
            put(any_but_newline());
      end
      put(CH_NL);
      put_filler();
      r   = $urandom_range(0, 9);
      sep = $urandom_range(0, 2) == 0 ? CH_TAB : CH_SPACE;
      if (r == 0)
         put_number(1'b0);
      else if (r == 1) begin
         put(sep);
         put_number(1'b1);
      end else begin
         put_number(1'b0);
         put(sep);
         put_number(1'b1);
      end
      put(CH_NL);
      put_filler();
      put_number(1'b1);
      put(CH_NL);
      repeat ($urandom_range(0, 6))
         put(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(0, file_buf.size());
         while (file_buf.size() > cut)
            void'(file_buf.pop_back());
      end
      put_eof();
   endtask

   // Sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.data_byte   <= '0;
         req_bus.end_of_file <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            void'(file_bytes.pop_front());
         if (req_bus.valid && !req_bus.ready) begin
            // hold the beat until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (file_bytes.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid       <= 1'b1;
            req_bus.data_byte   <= file_bytes[0].data_byte;
            req_bus.end_of_file <= file_bytes[0].end_of_file;
            if (burst_left > 1)
               burst_left--;
            else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // Sink: stall pattern steps through four modes, with two long hold-offs
   int rx_cycle  = 0;
   int rx_beats  = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_cycle  = 0;
         rx_beats  = 0;
         hold_left = 0;
      end else begin
         rx_cycle++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            rx_beats++;
            if (rx_beats == 5 || rx_beats == 30)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 64) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= $urandom_range(0, 1);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Monitor: check the result beat first, then predict from the accepted byte
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset)
         parser_restart();
      else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_headers.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: unexpected result: expected none, got status %0d magic %0d",
                           $time, rsp_bus.status, rsp_bus.magic_digit);
            end else begin
               want = expected_headers.pop_front();
               field_check("status", 32'(want.status), 32'(rsp_bus.status));
               field_check("magic_digit", 32'(want.magic_digit), 32'(rsp_bus.magic_digit));
               field_check("column_count", want.column_count, rsp_bus.column_count);
               field_check("row_total", want.row_total, rsp_bus.row_total);
               field_check("max_sample", want.max_sample, rsp_bus.max_sample);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (header_step(req_bus.data_byte, req_bus.end_of_file, want))
               expected_headers.push_back(want);
         end
      end
   end

   initial begin
      // empty file
      put_eof();
      // short magic line, then a byte ignored after the report
      put(CH_P);
      put(CH_NL);
      put(8'hFF);
      put_eof();
      // comment, blank line of a NUL, magic, size line with separator at the start
      put(CH_HASH);
      put(CH_NL);
      put(CH_NUL);
      put(CH_NL);
      put(CH_P);
      put(CH_ZERO + 8'd6);
      put(CH_NL);
      put(CH_SPACE);
      put(CH_ZERO + 8'd2);
      put(CH_NL);
      put_eof();
      // partial magic line flushed by end of file
      put(CH_P);
      put(CH_ZERO + 8'd3);
      put_eof();

      while (file_bytes.size() < RANDOM_BYTES + 20)
         make_file();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (file_bytes.size() != 0)
         @(posedge clock);
      @(posedge clock);
      while (expected_headers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && expected_headers.size() == 0)
         $display("pnm_header_parser test passed");
      else
         $display("pnm_header_parser test failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("pnm_header_parser test failed");
      $finish;
   end

endmodule
`default_nettype wire
